FILE: src/fpam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpam_pkg: shared types and constants
// Field widths, exponent constants and the sequencer state encoding.
// ----------------------------------------------------------------------------
package fpam_pkg;

  localparam int unsigned FracBits = 23;
  localparam int unsigned ExpBias  = 127;
  localparam int unsigned ExpW     = 10;

  localparam logic OpAdd = 1'b0;

  localparam logic signed [ExpW-1:0] ExpFloor = -10'sd127;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StAlign = 5'b00010,
    StMul   = 5'b00100,
    StNorm  = 5'b01000,
    StDone  = 5'b10000
  } state_e;

endpackage
`default_nettype wire

FILE: src/fp32_add_multiply_truncating.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fp32_add_multiply_truncating: iterative single-precision add/multiply
// Truncating add and multiply of IEEE-754 single patterns, no special values.
// ----------------------------------------------------------------------------
// One transaction at a time. Add: the operand with the smaller exponent is
// shifted right one bit at a time, by the exponent difference (up to 255),
// then the two are summed. Multiply: shift-and-add in one adder, leaving the
// full 48-bit product. Both then normalize one bit at a time (up to 24 bits)
// and load the output register. The result is held in an output register;
// the next transaction is accepted from the cycle after it is taken.
module fp32_add_multiply_truncating (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      result_bits_o
);

  localparam int unsigned EW = fpam_pkg::ExpW;

  fpam_pkg::state_e state_q, state_d;
  logic signed [EW-1:0] ea_q, eb_q, ex_q;
  logic signed [26:0] fa_q, fb_q;
  logic [47:0]       acc_q;
  logic [23:0]       mb_q;
  logic [4:0]        cnt_q;
  logic              sgn_q;
  logic [31:0]       res_q;
  logic              ov_q;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != fpam_pkg::StIdle) || ov_q;

  logic signed [27:0] sum;
  assign sum = {fa_q[26], fa_q} + {fb_q[26], fb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpam_pkg::StIdle;
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        fpam_pkg::StIdle: begin
          if (in_acc) begin
            state_q <= (op_i == fpam_pkg::OpAdd) ? fpam_pkg::StAlign : fpam_pkg::StMul;
          end
        end
        fpam_pkg::StAlign: begin
          if (ea_q == eb_q) state_q <= fpam_pkg::StNorm;
        end
        fpam_pkg::StMul: begin
          if (cnt_q == 5'd23) state_q <= fpam_pkg::StNorm;
        end
        fpam_pkg::StNorm: begin
          if (acc_q == 48'd0 || (acc_q[47:24] == 24'd0 && acc_q[23]))
            state_q <= fpam_pkg::StDone;
        end
        fpam_pkg::StDone: begin
          state_q <= fpam_pkg::StIdle;
          ov_q    <= 1'b1;
        end
        default: state_q <= fpam_pkg::StIdle;
      endcase
    end
  end

  logic [9:0] bexp;
  always_comb begin
    bexp = 10'(ex_q) + 10'(fpam_pkg::ExpBias);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      fpam_pkg::StIdle: begin
        ea_q  <= EW'($signed({2'b00, operand_a_i[30:23]})) - EW'(fpam_pkg::ExpBias);
        eb_q  <= EW'($signed({2'b00, operand_b_i[30:23]})) - EW'(fpam_pkg::ExpBias);
        fa_q  <= operand_a_i[31] ? -$signed({3'b000, 1'b1, operand_a_i[22:0]})
                                 :  $signed({3'b000, 1'b1, operand_a_i[22:0]});
        fb_q  <= operand_b_i[31] ? -$signed({3'b000, 1'b1, operand_b_i[22:0]})
                                 :  $signed({3'b000, 1'b1, operand_b_i[22:0]});
        mb_q  <= {1'b1, operand_b_i[22:0]};
        acc_q <= {24'd0, 1'b1, operand_a_i[22:0]};
        sgn_q <= operand_a_i[31] ^ operand_b_i[31];
        cnt_q <= 5'd0;
      end
      fpam_pkg::StAlign: begin
        if (ea_q < eb_q) begin
          fa_q <= fa_q >>> 1;
          ea_q <= ea_q + EW'(1);
        end else if (eb_q < ea_q) begin
          fb_q <= fb_q >>> 1;
          eb_q <= eb_q + EW'(1);
        end else begin
          ex_q  <= ea_q;
          sgn_q <= sum[27];
          acc_q <= sum[27] ? 48'(-sum) : 48'(sum);
        end
      end
      fpam_pkg::StMul: begin
        if (cnt_q == 5'd0) begin
          acc_q <= mb_q[0] ? {1'b0, acc_q[23:0], 23'd0} : 48'd0;
          fa_q  <= $signed({3'b000, acc_q[23:0]});
        end else begin
          acc_q <= 48'(({1'b0, acc_q} +
                        (mb_q[0] ? {1'b0, fa_q[23:0], 24'd0} : 49'd0)) >> 1);
        end
        mb_q  <= mb_q >> 1;
        cnt_q <= cnt_q + 5'd1;
        ex_q  <= ea_q + eb_q - EW'(fpam_pkg::FracBits);
      end
      fpam_pkg::StNorm: begin
        if (acc_q == 48'd0) begin
          ex_q <= fpam_pkg::ExpFloor;
        end else if (acc_q[47:24] != 24'd0) begin
          acc_q <= acc_q >> 1;
          ex_q  <= ex_q + EW'(1);
        end else if (!acc_q[23]) begin
          acc_q <= acc_q << 1;
          ex_q  <= ex_q - EW'(1);
        end
      end
      fpam_pkg::StDone: begin
        res_q <= {sgn_q,
                  (ex_q < fpam_pkg::ExpFloor) ? 8'd0 : bexp[7:0],
                  acc_q[22:0]};
      end
      default: ;
    endcase
  end

  assign out_valid_o   = ov_q;
  assign result_bits_o = res_q;

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fpam_pkg::StIdle) |-> in_stall_o) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpam_pkg::StDone) |=> out_valid_o) else $error("no result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(result_bits_o)) else $error("result moved");
`endif

endmodule
`default_nettype wire
